// ===== hw/rtl/gbi_pkg.sv =====
package gbi_pkg;

	localparam int COORD_W     = 32;
	localparam int LOAD_IDX_W  = 6;
	localparam int SAMPLE_IN_W = 16;
	localparam int VALUE_W     = 20;
	localparam int CFG_IDX_W   = 3;

	localparam int DEF_GRID_COLS     = 64;
	localparam int DEF_GRID_ROWS     = 64;
	localparam int DEF_SAMPLE_BITS   = 16;
	localparam int DEF_FRACTION_BITS = 16;

	localparam int VALUE_MAX = 524287;
	localparam int VALUE_MIN = -524288;

	localparam logic [31:0] RST_INV_SPACING = 32'd65536;
	localparam logic [5:0]  RST_BOUND_MAX   = 6'd63;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_INV_SPACE = 3'd2,
		CFG_COL_MIN   = 3'd3,
		CFG_COL_MAX   = 3'd4,
		CFG_ROW_MIN   = 3'd5,
		CFG_ROW_MAX   = 3'd6
	} cfg_reg_t;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

endpackage

// ===== hw/rtl/gbi_in_if.sv =====
interface gbi_in_if import gbi_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [LOAD_IDX_W-1:0]         load_col;
	logic [LOAD_IDX_W-1:0]         load_row;
	logic signed [SAMPLE_IN_W-1:0] sample;
	logic signed [COORD_W-1:0]     query_x;
	logic signed [COORD_W-1:0]     query_y;

	modport source(output valid, kind, load_col, load_row, sample, query_x, query_y,
		input ready);
	modport sink(input valid, kind, load_col, load_row, sample, query_x, query_y,
		output ready);
endinterface

// ===== hw/rtl/gbi_out_if.sv =====
interface gbi_out_if import gbi_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

// ===== hw/rtl/gbi_cfg_if.sv =====
interface gbi_cfg_if import gbi_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COORD_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gbi_ram.sv =====
module gbi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/gbi_fifo.sv =====
module gbi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             valid
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end
endmodule

// ===== hw/rtl/gbi_front.sv =====
module gbi_front import gbi_pkg::*; #(
	parameter int GRID_COLS     = DEF_GRID_COLS,
	parameter int GRID_ROWS     = DEF_GRID_ROWS,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS,
	parameter int ENT_W         = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	gbi_in_if.sink           item,
	gbi_cfg_if.sink          cfg,
	output logic             push,
	output logic [ENT_W-1:0] ent,
	input  logic             full
);
	localparam int AW = $clog2(GRID_COLS * GRID_ROWS);
	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int F  = FRACTION_BITS;
	localparam logic signed [35:0] COL_LAST = 36'(GRID_COLS - 1);
	localparam logic signed [35:0] ROW_LAST = 36'(GRID_ROWS - 1);

	typedef struct packed {
		logic                   is_query;
		logic [AW-1:0]          waddr;
		logic [SAMPLE_BITS-1:0] wdata;
		logic [3:0][CW-1:0]     cols;
		logic [3:0][RW-1:0]     rows;
		logic [F-1:0]           fx;
		logic [F-1:0]           fy;
	} entry_t;

	typedef enum logic [2:0] {F_IDLE, F_MULX, F_MULY, F_SPLITY, F_PUSH} fstate_t;

	fstate_t state_q;

	logic signed [31:0] origin_x_q, origin_y_q;
	logic [31:0]        inv_q;
	logic [5:0]         col_min_q, col_max_q, row_min_q, row_max_q;

	logic signed [31:0] qx_q, qy_q;
	logic [63:0]        prod_q;
	logic               neg_q;
	logic signed [33:0] ix_q, iy_q;
	logic [F-1:0]       fx_q, fy_q;

	logic signed [32:0] dsel;
	logic [31:0]        mag;
	logic signed [33:0] sp_idx;
	logic [31:0]        sp_lo;
	logic               take, in_grid;
	entry_t             wr_ent, q_ent;

	function automatic logic [35:0] clamp_idx(input logic signed [35:0] c,
		input logic [5:0] lo, input logic [5:0] hi, input logic signed [35:0] last);
		logic signed [35:0] v;
		v = c;
		if (v < $signed({30'd0, lo})) v = {30'd0, lo};
		if (v > $signed({30'd0, hi})) v = {30'd0, hi};
		if (v > last) v = last;
		if (v < 0) v = '0;
		return v;
	endfunction

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == F_IDLE) && !full;
	assign take       = item.valid && item.ready;
	assign in_grid    = (32'(item.load_col) < GRID_COLS) && (32'(item.load_row) < GRID_ROWS);

	// one shared 32x32 multiplier, x axis then y axis
	always_comb begin
		if (state_q == F_MULX) begin
			dsel = {qx_q[31], qx_q} - {origin_x_q[31], origin_x_q};
		end else begin
			dsel = {qy_q[31], qy_q} - {origin_y_q[31], origin_y_q};
		end
		mag = dsel[32] ? 32'(-dsel) : dsel[31:0];
	end

	// floor of the signed product; fraction is measured up from the floor
	always_comb begin
		sp_lo = prod_q[31:0];
		if (!neg_q) begin
			sp_idx = {2'b00, prod_q[63:32]};
		end else if (prod_q[31:0] == '0) begin
			sp_idx = -$signed({2'b00, prod_q[63:32]});
		end else begin
			sp_idx = -$signed({2'b00, prod_q[63:32]}) - 34'sd1;
			sp_lo  = -prod_q[31:0];
		end
	end

	always_comb begin
		wr_ent          = '0;
		wr_ent.is_query = KIND_LOAD;
		wr_ent.waddr    = AW'(item.load_row) * AW'(GRID_COLS) + AW'(item.load_col);
		wr_ent.wdata    = SAMPLE_BITS'(item.sample);
		q_ent           = '0;
		q_ent.is_query  = KIND_QUERY;
		q_ent.fx        = fx_q;
		q_ent.fy        = fy_q;
		for (int a = 0; a < 4; a++) begin
			q_ent.cols[a] = CW'(clamp_idx(36'(ix_q) + 36'(a) - 36'sd1,
				col_min_q, col_max_q, COL_LAST));
			q_ent.rows[a] = RW'(clamp_idx(36'(iy_q) + 36'(a) - 36'sd1,
				row_min_q, row_max_q, ROW_LAST));
		end
	end

	assign push = (take && (item.kind == KIND_LOAD) && in_grid)
		|| ((state_q == F_PUSH) && !full);
	assign ent  = (state_q == F_PUSH) ? ENT_W'(q_ent) : ENT_W'(wr_ent);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_q      <= RST_INV_SPACING;
			col_min_q  <= '0;
			col_max_q  <= RST_BOUND_MAX;
			row_min_q  <= '0;
			row_max_q  <= RST_BOUND_MAX;
		end else begin
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					CFG_ORIGIN_X:  origin_x_q <= cfg.data;
					CFG_ORIGIN_Y:  origin_y_q <= cfg.data;
					CFG_INV_SPACE: inv_q      <= cfg.data;
					CFG_COL_MIN:   col_min_q  <= cfg.data[5:0];
					CFG_COL_MAX:   col_max_q  <= cfg.data[5:0];
					CFG_ROW_MIN:   row_min_q  <= cfg.data[5:0];
					CFG_ROW_MAX:   row_max_q  <= cfg.data[5:0];
					default: ;
				endcase
			end
			case (state_q)
				F_IDLE: begin
					if (take && (item.kind == KIND_QUERY)) begin
						state_q <= F_MULX;
					end
				end
				F_MULX:   state_q <= F_MULY;
				F_MULY:   state_q <= F_SPLITY;
				F_SPLITY: state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			qx_q <= item.query_x;
			qy_q <= item.query_y;
		end
		if (state_q == F_MULX || state_q == F_MULY) begin
			prod_q <= 64'(mag) * 64'(inv_q);
			neg_q  <= dsel[32];
		end
		if (state_q == F_MULY) begin
			ix_q <= sp_idx;
			fx_q <= sp_lo[31 -: F];
		end
		if (state_q == F_SPLITY) begin
			iy_q <= sp_idx;
			fy_q <= sp_lo[31 -: F];
		end
	end
endmodule

// ===== hw/rtl/gbi_back.sv =====
module gbi_back import gbi_pkg::*; #(
	parameter int GRID_COLS     = DEF_GRID_COLS,
	parameter int GRID_ROWS     = DEF_GRID_ROWS,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS,
	parameter int ENT_W         = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [ENT_W-1:0] q_data,
	output logic             pop,
	gbi_out_if.source        result
);
	localparam int AW = $clog2(GRID_COLS * GRID_ROWS);
	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int F  = FRACTION_BITS;
	localparam int W  = (SAMPLE_BITS + 10 > 24) ? SAMPLE_BITS + 10 : 24;
	localparam int PW = W + F + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);
	localparam logic signed [W-1:0]  VMAX = W'(VALUE_MAX);
	localparam logic signed [W-1:0]  VMIN = W'(VALUE_MIN);

	typedef struct packed {
		logic                   is_query;
		logic [AW-1:0]          waddr;
		logic [SAMPLE_BITS-1:0] wdata;
		logic [3:0][CW-1:0]     cols;
		logic [3:0][RW-1:0]     rows;
		logic [F-1:0]           fx;
		logic [F-1:0]           fy;
	} entry_t;

	typedef enum logic [2:0] {B_IDLE, B_READ, B_LAST, B_CR, B_OUT} bstate_t;

	bstate_t state_q;
	entry_t  head, cur_q;

	logic [1:0] colc_q, rowc_q, step_q;
	logic       pass_y_q, rdv_q;

	logic signed [SAMPLE_BITS-1:0] line_q [4];
	logic signed [W-1:0]           col4_q [4];
	logic signed [W-1:0]           acc_q;
	logic signed [VALUE_W-1:0]     value_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_addr, raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	logic signed [W-1:0]  p [4];
	logic signed [W-1:0]  d1, d2, d3, addend, acc_nx, fin;
	logic [F-1:0]         f;
	logic signed [PW-1:0] prod;

	assign head = entry_t'(q_data);
	assign pop  = (state_q == B_IDLE) && q_valid;

	assign ram_we   = pop && (head.is_query == KIND_LOAD);
	assign raddr    = AW'(cur_q.rows[rowc_q]) * AW'(GRID_COLS) + AW'(cur_q.cols[colc_q]);
	assign ram_addr = ram_we ? head.waddr : raddr;

	gbi_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(GRID_COLS * GRID_ROWS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (head.wdata),
		.rdata (ram_rdata)
	);

	// Catmull-Rom, doubled, one Horner step per cycle on a shared multiplier
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			p[k] = pass_y_q ? col4_q[k] : W'(line_q[k]);
		end
		f  = pass_y_q ? cur_q.fy : cur_q.fx;
		d1 = p[2] - p[0];
		d2 = (p[0] <<< 1) - ((p[1] <<< 2) + p[1]) + (p[2] <<< 2) - p[3];
		d3 = -p[0] + ((p[1] <<< 1) + p[1]) - ((p[2] <<< 1) + p[2]) + p[3];
		case (step_q)
			2'd1:    addend = d2;
			2'd2:    addend = d1;
			default: addend = p[1] <<< 1;
		endcase
		prod   = acc_q * $signed({1'b0, f});
		acc_nx = addend + W'((prod + HALF) >>> F);
		fin    = (acc_nx + W'(2)) >>> 2;
	end

	assign result.valid = (state_q == B_OUT);
	assign result.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			colc_q   <= '0;
			rowc_q   <= '0;
			step_q   <= '0;
			pass_y_q <= 1'b0;
			rdv_q    <= 1'b0;
		end else begin
			rdv_q <= (state_q == B_READ);
			case (state_q)
				B_IDLE: begin
					if (pop && (head.is_query == KIND_QUERY)) begin
						state_q  <= B_READ;
						colc_q   <= '0;
						rowc_q   <= '0;
						pass_y_q <= 1'b0;
					end
				end
				B_READ: begin
					colc_q <= colc_q + 1'b1;
					if (colc_q == 2'd3) begin
						state_q <= B_LAST;
					end
				end
				B_LAST: begin
					state_q <= B_CR;
					step_q  <= '0;
				end
				B_CR: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						if (pass_y_q) begin
							state_q <= B_OUT;
						end else if (rowc_q == 2'd3) begin
							pass_y_q <= 1'b1;
						end else begin
							rowc_q  <= rowc_q + 1'b1;
							state_q <= B_READ;
						end
					end
				end
				B_OUT: begin
					if (result.ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (rdv_q) begin
			line_q[3] <= ram_rdata;
			for (int k = 0; k < 3; k++) begin
				line_q[k] <= line_q[k + 1];
			end
		end
		if (state_q == B_CR) begin
			acc_q <= (step_q == 2'd0) ? d3 : acc_nx;
			if (step_q == 2'd3 && !pass_y_q) begin
				col4_q[3] <= acc_nx;
				for (int k = 0; k < 3; k++) begin
					col4_q[k] <= col4_q[k + 1];
				end
			end
			if (step_q == 2'd3 && pass_y_q) begin
				if (fin > VMAX) begin
					value_q <= VALUE_W'(VMAX);
				end else if (fin < VMIN) begin
					value_q <= VALUE_W'(VMIN);
				end else begin
					value_q <= VALUE_W'(fin);
				end
			end
		end
	end
endmodule

// ===== hw/rtl/bicubic_grid_interpolator_core.sv =====
// Catmull-Rom bicubic interpolator over a sample grid held in one RAM.
// Load word: written to the RAM as the back end pops it, one load per cycle when the queue drains.
// Query word: front end steps MULX, MULY, SPLITY, PUSH (two passes of one 32x32
// multiplier); back end: 16 reads through the single RAM port plus five 4-step
// Horner passes on one shared multiplier. One query in the back end at a time.
// arst_n clears control and config to defaults; grid RAM is undefined until loaded.
module bicubic_grid_interpolator_core import gbi_pkg::*; #(
	parameter int GRID_COLS     = DEF_GRID_COLS,
	parameter int GRID_ROWS     = DEF_GRID_ROWS,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input logic       clk,
	input logic       arst_n,
	gbi_in_if.sink    item,
	gbi_cfg_if.sink   cfg,
	gbi_out_if.source result
);
	localparam int AW    = $clog2(GRID_COLS * GRID_ROWS);
	localparam int ENT_W = 1 + AW + SAMPLE_BITS + 4 * $clog2(GRID_COLS)
		+ 4 * $clog2(GRID_ROWS) + 2 * FRACTION_BITS;

	logic             q_push, q_full, q_pop, q_valid;
	logic [ENT_W-1:0] q_din, q_dout;

	gbi_front #(
		.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS), .ENT_W(ENT_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.push   (q_push),
		.ent    (q_din),
		.full   (q_full)
	);

	gbi_fifo #(.WIDTH(ENT_W), .DEPTH(2)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	gbi_back #(
		.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS), .ENT_W(ENT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_dout),
		.pop     (q_pop),
		.result  (result)
	);

	// front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !q_push)
		else $error("push into full queue");

	// back end takes no new word while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n) result.valid |-> !q_pop)
		else $error("pop while result pending");

	// a pop always finds a word in the queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
endmodule
